### rtl/cfp_pkg.sv
`timescale 1ns / 1ps
// Package for the continued fraction convergent denominator search.
// Holds the datapath width and derived counter width; no dependencies.
package cfp_pkg;

    // Datapath width of the expansion (inputs are cut or zero-extended to it)
    localparam int WIDTH = 32;

    // Bit counter of the shared divide/multiply loop
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

endpackage

### rtl/continued_fraction_period.sv
`timescale 1ns / 1ps
// A zero denominator goes straight to the result. Otherwise the block runs quotient steps until
// a denominator reaches the limit or the remainder is zero (at most about 1.44 * WIDTH + 2 steps).
// Each step runs the shared restoring-divide / shift-add-multiply loop over the WIDTH dividend
// bits, then adds the older denominator and compares against the limit. The block takes no new
// item until the last result has been taken.
// One item at a time: in_ready is high only while no item is being worked or held.
// Reset (rst_n low, asynchronous) returns to idle with no result pending.
//
// Continued fraction convergent denominator search: top level and only module.
// Depends on cfp_pkg.
module continued_fraction_period
    import cfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] frac_numerator,
    input  logic [31:0] frac_denominator,
    input  logic [31:0] limit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] period,
    output logic        valid_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH,
        ST_DONE
    } state_t;

    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] rem_high_reg, rem_high_next;
    logic [WIDTH-1:0] rem_low_reg, rem_low_next;
    logic [WIDTH-1:0] denom_older_reg, denom_older_next;
    logic [WIDTH-1:0] denom_newer_reg, denom_newer_next;
    logic [WIDTH-1:0] part_rem_reg, part_rem_next;
    logic [WIDTH-1:0] prod_reg, prod_next;
    logic             sat_reg, sat_next;
    logic [WIDTH-1:0] lim_reg, lim_next;
    logic [WIDTH-1:0] best_reg, best_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Shared unit signals
    logic [WIDTH:0]   shifted;
    logic             q_bit;
    logic [WIDTH:0]   sub_res;
    logic [WIDTH+1:0] prod_sum;
    logic [WIDTH:0]   mac_sum;
    logic [WIDTH-1:0] k_val;
    logic [WIDTH-1:0] num_in;
    logic [WIDTH-1:0] den_in;

    assign num_in = WIDTH'(frac_numerator);
    assign den_in = WIDTH'(frac_denominator);

    // Restoring divide step: bring in the next dividend bit, subtract if it fits
    assign shifted = {part_rem_reg, rem_high_reg[WIDTH-1]};
    assign q_bit   = (shifted >= {1'b0, rem_low_reg});
    assign sub_res = shifted - {1'b0, rem_low_reg};

    // Shift-add multiply of the quotient by denom_newer, MSB first
    assign prod_sum = {1'b0, prod_reg, 1'b0}
                    + {2'b00, (q_bit ? denom_newer_reg : {WIDTH{1'b0}})};

    // Add the older denominator and saturate
    assign mac_sum = {1'b0, prod_reg} + {1'b0, denom_older_reg};
    assign k_val   = (sat_reg || mac_sum[WIDTH]) ? ALL_ONES : mac_sum[WIDTH-1:0];

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        rem_high_next    = rem_high_reg;
        rem_low_next     = rem_low_reg;
        denom_older_next = denom_older_reg;
        denom_newer_next = denom_newer_reg;
        part_rem_next    = part_rem_reg;
        prod_next        = prod_reg;
        sat_next         = sat_reg;
        lim_next         = lim_reg;
        best_next        = best_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rem_high_next    = num_in;
                    rem_low_next     = den_in;
                    denom_older_next = {{(WIDTH-1){1'b0}}, 1'b1};
                    denom_newer_next = '0;
                    lim_next         = WIDTH'(limit);
                    best_next        = '0;
                    part_rem_next    = '0;
                    prod_next        = '0;
                    sat_next         = 1'b0;
                    cnt_next         = CNT_LAST;
                    if (den_in == '0)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                rem_high_next = {rem_high_reg[WIDTH-2:0], 1'b0};
                part_rem_next = q_bit ? sub_res[WIDTH-1:0] : shifted[WIDTH-1:0];
                prod_next     = prod_sum[WIDTH-1:0];
                sat_next      = sat_reg || (prod_sum[WIDTH+1:WIDTH] != 2'b00);
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Advance the remainder pair and the denominator pair
                rem_high_next    = rem_low_reg;
                rem_low_next     = part_rem_reg;
                denom_older_next = denom_newer_reg;
                denom_newer_next = k_val;
                part_rem_next    = '0;
                prod_next        = '0;
                sat_next         = 1'b0;
                cnt_next         = CNT_LAST;
                if (k_val < lim_reg)
                begin
                    best_next = k_val;
                end
                if ((k_val >= lim_reg) || (part_rem_reg == '0))
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    // Dividend is the old divisor: load it straight into the shifter
                    state_next = ST_DIV;
                end
            end

            ST_DONE:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rem_high_reg    <= '0;
            rem_low_reg     <= '0;
            denom_older_reg <= {{(WIDTH-1){1'b0}}, 1'b1};
            denom_newer_reg <= '0;
            part_rem_reg    <= '0;
            prod_reg        <= '0;
            sat_reg         <= 1'b0;
            lim_reg         <= '0;
            best_reg        <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rem_high_reg    <= rem_high_next;
            rem_low_reg     <= rem_low_next;
            denom_older_reg <= denom_older_next;
            denom_newer_reg <= denom_newer_next;
            part_rem_reg    <= part_rem_next;
            prod_reg        <= prod_next;
            sat_reg         <= sat_next;
            lim_reg         <= lim_next;
            best_reg        <= best_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign period    = 32'(best_reg);
    assign valid_res = (best_reg != '0);

    // Checks on the sequencer and the shared unit
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result is held");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_low_reg != '0))
        else $error("divide step with zero divisor");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (part_rem_reg < rem_low_reg))
        else $error("partial remainder not below divisor");

    a_best_below: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (best_reg < lim_reg))
        else $error("reported denominator not below limit");

    a_done_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (state_reg == ST_DONE) && !$past(in_ready && in_valid
            && (den_in != '0)))
        else $error("result raised without a finished expansion");

endmodule
